// ===== hw/rtl/fis_pkg.sv =====
// Package for the FASTA index scanner: byte codes, output widths, event types.
`timescale 1ns / 1ps

package fis_pkg;

  localparam int OUT_OFFSET_W = 40;
  localparam int OUT_INDEX_W  = 20;

  localparam logic [7:0] BYTE_NL = 8'd10;
  localparam logic [7:0] BYTE_GT = 8'd62;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_EOF  = 1'b1;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_HDR_END,
    OP_NEW_SEQ,
    OP_EOF
  } op_t;

  typedef struct packed {
    op_t  op;
    logic emit;
    logic hdr;
  } evt_t;

endpackage

// ===== hw/rtl/fasta_index_scanner.sv =====
// Top level of the FASTA index scanner.
// Takes one FASTA file byte (or an end-of-file item) per cycle while the queue
// has room and emits one record per completed sequence: ordinal, concatenated
// start, base count and file offset of the first base. A front end classifies
// each byte against the line state, a two-entry queue carries the resulting
// events to the back end, and the back end updates the sequence counters and
// holds the record in an output register. Sustained rate is one item per cycle
// while out_ready is high; each record goes through the queue stage and the
// output register. Counters wrap at OFFSET_BITS, the ordinal at INDEX_BITS.
`timescale 1ns / 1ps

module fasta_index_scanner #(
  parameter int OFFSET_BITS = 40,
  parameter int INDEX_BITS  = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fis_pkg::OUT_INDEX_W-1:0]   out_record_index,
  output logic [fis_pkg::OUT_OFFSET_W-1:0]  out_concat_start,
  output logic [fis_pkg::OUT_OFFSET_W-1:0]  out_record_length,
  output logic [fis_pkg::OUT_OFFSET_W-1:0]  out_record_file_offset,
  output logic                              out_is_final
);

  localparam int QBITS = $bits(fis_pkg::evt_t) + OFFSET_BITS;

  logic                   push, q_full, q_valid, q_pop;
  fis_pkg::evt_t          push_evt, head_evt;
  logic [OFFSET_BITS-1:0] push_off, head_off;
  logic [QBITS-1:0]       head_data;

  fis_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .push         (push),
    .push_evt     (push_evt),
    .push_off     (push_off),
    .q_full       (q_full)
  );

  fis_queue #(.DATA_BITS(QBITS)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_evt, push_off}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_data)
  );

  assign head_evt = head_data[QBITS-1:OFFSET_BITS];
  assign head_off = head_data[OFFSET_BITS-1:0];

  fis_back #(.OFFSET_BITS(OFFSET_BITS), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_valid),
    .q_pop                  (q_pop),
    .q_evt                  (head_evt),
    .q_off                  (head_off),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_record_index       (out_record_index),
    .out_concat_start       (out_concat_start),
    .out_record_length      (out_record_length),
    .out_record_file_offset (out_record_file_offset),
    .out_is_final           (out_is_final)
  );

endmodule

// ===== hw/rtl/fis_front.sv =====
// Front end: tracks line state and byte offset, turns bytes into back-end events.
`timescale 1ns / 1ps

module fis_front #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [7:0]             in_data_byte,
  output logic                   push,
  output fis_pkg::evt_t          push_evt,
  output logic [OFFSET_BITS-1:0] push_off,
  input  logic                   q_full
);

  logic [OFFSET_BITS-1:0] byte_off_r, byte_off_nxt;
  logic                   line_start_r, line_start_nxt;
  logic                   in_hdr_r, in_hdr_nxt;
  logic                   seq_open_r, seq_open_nxt;
  logic [OFFSET_BITS-1:0] off_inc;
  logic                   take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign off_inc  = byte_off_r + OFFSET_BITS'(1);

  always_comb begin
    byte_off_nxt   = byte_off_r;
    line_start_nxt = line_start_r;
    in_hdr_nxt     = in_hdr_r;
    seq_open_nxt   = seq_open_r;
    push           = 1'b0;
    push_evt.op    = fis_pkg::OP_COUNT;
    push_evt.emit  = 1'b0;
    push_evt.hdr   = in_hdr_r;
    push_off       = off_inc;
    if (take) begin
      if (in_func == fis_pkg::FUNC_EOF) begin
        push           = 1'b1;
        push_evt.op    = fis_pkg::OP_EOF;
        push_evt.emit  = seq_open_r;
        byte_off_nxt   = '0;
        line_start_nxt = 1'b1;
        in_hdr_nxt     = 1'b0;
        seq_open_nxt   = 1'b0;
      end else begin
        byte_off_nxt = off_inc;
        if (in_data_byte == fis_pkg::BYTE_NL) begin
          push           = in_hdr_r;
          push_evt.op    = fis_pkg::OP_HDR_END;
          in_hdr_nxt     = 1'b0;
          line_start_nxt = 1'b1;
        end else if (line_start_r && in_data_byte == fis_pkg::BYTE_GT) begin
          push           = 1'b1;
          push_evt.op    = fis_pkg::OP_NEW_SEQ;
          push_evt.emit  = seq_open_r;
          seq_open_nxt   = 1'b1;
          in_hdr_nxt     = 1'b1;
          line_start_nxt = 1'b0;
        end else begin
          push           = !in_hdr_r;
          push_evt.op    = fis_pkg::OP_COUNT;
          line_start_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_off_r   <= '0;
      line_start_r <= 1'b1;
      in_hdr_r     <= 1'b0;
      seq_open_r   <= 1'b0;
    end else begin
      byte_off_r   <= byte_off_nxt;
      line_start_r <= line_start_nxt;
      in_hdr_r     <= in_hdr_nxt;
      seq_open_r   <= seq_open_nxt;
    end
  end

endmodule

// ===== hw/rtl/fis_queue.sv =====
// Two-entry event queue between front and back.
`timescale 1ns / 1ps

module fis_queue #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output logic [DATA_BITS-1:0] head_data
);

  logic [DATA_BITS-1:0] mem_r [2];
  logic                 wr_ptr_r, rd_ptr_r;
  logic [1:0]           count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 2'd1;
    else if (!do_push && do_pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/fis_back.sv =====
// Back end: sequence counters and the registered record output.
`timescale 1ns / 1ps

module fis_back #(
  parameter int OFFSET_BITS = 40,
  parameter int INDEX_BITS  = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  fis_pkg::evt_t                     q_evt,
  input  logic [OFFSET_BITS-1:0]            q_off,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fis_pkg::OUT_INDEX_W-1:0]   out_record_index,
  output logic [fis_pkg::OUT_OFFSET_W-1:0]  out_concat_start,
  output logic [fis_pkg::OUT_OFFSET_W-1:0]  out_record_length,
  output logic [fis_pkg::OUT_OFFSET_W-1:0]  out_record_file_offset,
  output logic                              out_is_final
);

  localparam int OEXT = (OFFSET_BITS > fis_pkg::OUT_OFFSET_W) ? OFFSET_BITS
                                                              : fis_pkg::OUT_OFFSET_W;
  localparam int IEXT = (INDEX_BITS > fis_pkg::OUT_INDEX_W) ? INDEX_BITS
                                                            : fis_pkg::OUT_INDEX_W;

  logic [OFFSET_BITS-1:0] bc_r, bc_nxt;
  logic [OFFSET_BITS-1:0] fbo_r, fbo_nxt;
  logic [OFFSET_BITS-1:0] concat_r, concat_nxt;
  logic [INDEX_BITS-1:0]  rec_r, rec_nxt;
  logic [OFFSET_BITS-1:0] fbo_eff;
  logic                   out_valid_r, out_valid_nxt;
  logic                   emit;
  logic [OEXT-1:0]        cs_ext, len_ext, fo_ext;
  logic [IEXT-1:0]        idx_ext;

  assign q_pop   = q_valid && (!out_valid_r || out_ready);
  assign emit    = q_pop && q_evt.emit &&
                   (q_evt.op == fis_pkg::OP_NEW_SEQ || q_evt.op == fis_pkg::OP_EOF);
  assign fbo_eff = (q_evt.op == fis_pkg::OP_EOF && q_evt.hdr) ? q_off : fbo_r;
  assign cs_ext  = OEXT'(concat_r);
  assign len_ext = OEXT'(bc_r);
  assign fo_ext  = OEXT'(fbo_eff);
  assign idx_ext = IEXT'(rec_r);

  always_comb begin
    bc_nxt        = bc_r;
    fbo_nxt       = fbo_r;
    concat_nxt    = concat_r;
    rec_nxt       = rec_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
      rec_nxt       = rec_r + INDEX_BITS'(1);
      concat_nxt    = concat_r + bc_r;
    end
    if (q_pop) begin
      case (q_evt.op)
        fis_pkg::OP_COUNT:   bc_nxt = bc_r + OFFSET_BITS'(1);
        fis_pkg::OP_HDR_END: fbo_nxt = q_off;
        fis_pkg::OP_NEW_SEQ: bc_nxt = '0;
        fis_pkg::OP_EOF: begin
          bc_nxt     = '0;
          fbo_nxt    = '0;
          concat_nxt = '0;
          rec_nxt    = '0;
        end
        default: bc_nxt = bc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r        <= '0;
      fbo_r       <= '0;
      concat_r    <= '0;
      rec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bc_r        <= bc_nxt;
      fbo_r       <= fbo_nxt;
      concat_r    <= concat_nxt;
      rec_r       <= rec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_record_index       <= idx_ext[fis_pkg::OUT_INDEX_W-1:0];
      out_concat_start       <= cs_ext[fis_pkg::OUT_OFFSET_W-1:0];
      out_record_length      <= len_ext[fis_pkg::OUT_OFFSET_W-1:0];
      out_record_file_offset <= fo_ext[fis_pkg::OUT_OFFSET_W-1:0];
      out_is_final           <= (q_evt.op == fis_pkg::OP_EOF);
    end
  end

  assign out_valid = out_valid_r;

  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_evt.op == fis_pkg::OP_EOF |=> bc_r == '0 && rec_r == '0 && concat_r == '0)
    else $error("end of file did not clear back-end counters");

  a_concat_adv: assert property (@(posedge clk) disable iff (!rst_n)
    emit && q_evt.op == fis_pkg::OP_NEW_SEQ |=>
      concat_r == OFFSET_BITS'($past(concat_r) + $past(bc_r)))
    else $error("concatenated start did not advance by record length");

  a_new_seq_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_evt.op == fis_pkg::OP_NEW_SEQ |=> bc_r == '0)
    else $error("base count not cleared on new sequence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !q_pop)
    else $error("queue popped while record output stalled");

endmodule
